// File: hdl/spi_master_tx_queue_cs_control_unit_defines.svh
// assertion helpers shared by the checker
`ifndef SPI_MASTER_TX_QUEUE_CS_CONTROL_UNIT_DEFINES_SVH
`define SPI_MASTER_TX_QUEUE_CS_CONTROL_UNIT_DEFINES_SVH

// concurrent assertion on clk_i, quiet while rst_ni is low
`define SMTQCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form, antecedent and consequent given apart
`define SMTQCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/smtqcs_pkg.sv
package smtqcs_pkg;

  localparam int FifoDepth = 32;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int CmpW      = ((CntW > 8) ? CntW : 8) + 1;

  localparam logic [1:0] CfgCsActiveHigh   = 2'd0;
  localparam logic [1:0] CfgRxEnabled      = 2'd1;
  localparam logic [1:0] CfgTxQueueEnabled = 2'd2;

  localparam logic CmdSend  = 1'b0;
  localparam logic CmdEvent = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       first_of_string;
    logic [7:0] string_length;
    logic [7:0] received_byte;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       shift_valid;
    logic [7:0] shift_byte;
    logic       cs_level;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_pulse;
  } res_t;

  typedef struct packed {
    logic cs_active_high;
    logic rx_enabled;
    logic tx_queue_enabled;
  } cfg_t;

  // decoded operation handed from front to back
  typedef struct packed {
    logic       is_event;
    logic       first;
    logic       len_one;
    logic [7:0] len;
    logic [7:0] data_byte;
    logic [7:0] rx_byte;
  } op_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StRead = 3'b100
  } back_state_e;

endpackage

// File: hdl/spi_master_tx_queue_cs_control_unit.sv
// SPI master sequencing core: takes send elements and transfer-complete events, one result
// beat per input beat in order. Input beats land in a two-entry op queue, so the front keeps
// accepting while the back is busy or the output is stalled, until the queue is full. The back
// handles one op at a time: it captures an op, then executes it, passing through a read step
// when a completion pops the next byte from the 32-entry transmit FIFO, whose read port is
// registered. The FIFO needs no clearing pass after reset; only counted entries are read. Config
// writes are always ready and should be issued only when the block is idle.
module spi_master_tx_queue_cs_control_unit import smtqcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic op_valid, op_ready;
  op_t  op;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCsActiveHigh:   cfg_d.cs_active_high   = cfg_data_i;
        CfgRxEnabled:      cfg_d.rx_enabled       = cfg_data_i;
        CfgTxQueueEnabled: cfg_d.tx_queue_enabled = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cs_active_high   <= 1'b0;
      cfg_q.rx_enabled       <= 1'b1;
      cfg_q.tx_queue_enabled <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  smtqcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  smtqcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/smtqcs_front.sv
module smtqcs_front import smtqcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic op_valid_o,
  input  logic op_ready_i,
  output op_t  op_o
);

  op_t        op_in;
  op_t        q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // zero length counts as one byte
  always_comb begin
    op_in.is_event  = (in_data_i.cmd == CmdEvent);
    op_in.first     = in_data_i.first_of_string;
    op_in.len_one   = (in_data_i.string_length <= 8'd1);
    op_in.len       = (in_data_i.string_length == 8'd0) ? 8'd1 : in_data_i.string_length;
    op_in.data_byte = in_data_i.data_byte;
    op_in.rx_byte   = in_data_i.received_byte;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = q_mem[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hdl/smtqcs_back.sv
module smtqcs_back import smtqcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic op_valid_i,
  output logic op_ready_o,
  input  op_t  op_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  back_state_e     state_q, state_d;
  op_t             op_q;
  logic [7:0]      tx_mem [FifoDepth];
  logic [7:0]      rd_data_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            active_q, active_d;
  logic            rejected_q, rejected_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, res;
  logic            out_free, load, mem_we;
  logic [CmpW-1:0] room;
  logic            rej, accept, fifo_full, fifo_empty, active_n;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign op_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign room       = CmpW'(FifoDepth) - CmpW'(count_q);
  assign fifo_full  = (count_q == CntW'(FifoDepth));
  assign fifo_empty = (count_q == '0);

  always_comb begin
    state_d    = state_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    count_d    = count_q;
    active_d   = active_q;
    rejected_d = rejected_q;
    load       = 1'b0;
    mem_we     = 1'b0;
    res        = '0;
    rej        = 1'b0;
    accept     = 1'b0;
    active_n   = active_q;

    case (state_q)
      StIdle: begin
        if (op_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (op_q.is_event && active_q && !fifo_empty) begin
          // byte still queued, fetch it first
          state_d = StRead;
        end else if (out_free) begin
          load    = 1'b1;
          state_d = StIdle;
          if (op_q.is_event) begin
            res.done_pulse = 1'b1;
            res.rx_valid   = cfg_i.rx_enabled;
            res.rx_byte    = cfg_i.rx_enabled ? op_q.rx_byte : 8'd0;
            active_n       = 1'b0;
          end else begin
            if (cfg_i.tx_queue_enabled) begin
              rej = (CmpW'(op_q.len) > room);
            end else begin
              rej = !op_q.len_one || active_q;
            end
            if (op_q.first) begin
              rejected_d = rej;
              accept     = !rej;
            end else begin
              accept = !rejected_q && cfg_i.tx_queue_enabled;
            end
            if (accept) begin
              if (!active_q) begin
                active_n         = 1'b1;
                res.shift_valid  = 1'b1;
                res.shift_byte   = op_q.data_byte;
              end else if (fifo_full) begin
                res.status = 1'b1;
              end else begin
                mem_we   = 1'b1;
                wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
                count_d  = count_q + 1'b1;
              end
            end else begin
              res.status = 1'b1;
            end
          end
          active_d     = active_n;
          res.cs_level = active_n ? cfg_i.cs_active_high : !cfg_i.cs_active_high;
        end
      end
      StRead: begin
        if (out_free) begin
          load            = 1'b1;
          state_d         = StIdle;
          res.done_pulse  = 1'b1;
          res.rx_valid    = cfg_i.rx_enabled;
          res.rx_byte     = cfg_i.rx_enabled ? op_q.rx_byte : 8'd0;
          res.shift_valid = 1'b1;
          res.shift_byte  = rd_data_q;
          res.cs_level    = cfg_i.cs_active_high;
          rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // no writes happen on the pop path, so the read address stays coherent
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tx_mem[wr_ptr_q] <= op_q.data_byte;
    end
    rd_data_q <= tx_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_ready_o) begin
      op_q <= op_i;
    end
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      rejected_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      active_q    <= active_d;
      rejected_q  <= rejected_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/smtqcs_checker.sv
`include "spi_master_tx_queue_cs_control_unit_defines.svh"

module smtqcs_checker import smtqcs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input res_t out_data_o
);

  // a stalled result beat stays up and unchanged
  `SMTQCS_ASSERT_IMP(a_out_hold, out_valid_o && out_stall_i, ##1 out_valid_o, "out beat dropped")
  `SMTQCS_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o), "beat changed")
  // completions never report no room
  `SMTQCS_ASSERT_IMP(a_done_ok, out_valid_o && out_data_o.done_pulse, !out_data_o.status, "st on done")
  // a discarded receive byte reads as zero
  `SMTQCS_ASSERT_IMP(a_rx_zero, out_valid_o && !out_data_o.rx_valid, out_data_o.rx_byte == 8'd0, "rx")

endmodule

bind spi_master_tx_queue_cs_control_unit smtqcs_checker u_smtqcs_checker (.*);
